/* hdl/ncl_pkg.sv */
// ----------------------------------------------------------------------------
// ncl_pkg: shared types and constants
// Command codes, register indices, sizes, reset values, timer limits and the
// histogram control group of the node command and level controller.
// ----------------------------------------------------------------------------
package ncl_pkg;

  localparam int unsigned LevelsDefault = 64;
  localparam int unsigned RingDepth     = 32;

  localparam logic [2:0] CmdClear      = 3'd0;
  localparam logic [2:0] CmdLedOn      = 3'd1;
  localparam logic [2:0] CmdLedOff     = 3'd2;
  localparam logic [2:0] CmdWave       = 3'd3;
  localparam logic [2:0] CmdDiscover   = 3'd4;
  localparam logic [2:0] CmdProximity  = 3'd5;
  localparam logic [2:0] CmdShutdown   = 3'd6;
  localparam logic [2:0] CmdBlinkLevel = 3'd7;

  localparam logic       RegActionDelay = 1'b0;
  localparam logic       RegTicksPerHalf = 1'b1;

  localparam logic [4:0] HistLenReset     = 5'd15;
  localparam logic [7:0] PowerReset       = 8'd70;
  localparam logic [7:0] ActionDelayReset = 8'd160;
  localparam logic [6:0] TphsReset        = 7'd8;
  localparam logic [2:0] BlinkOnTicks     = 3'd4;
  localparam logic [1:0] DiscoverLast     = 2'd2;

  // Control group from the sequencer to the histogram store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } hist_ctl_t;

endpackage

/* hdl/ncl_hist.sv */
// ----------------------------------------------------------------------------
// ncl_hist: level histogram store
// One count per level in a single-port-write, registered-read memory, with
// a valid bit per entry so that a clear empties every entry at once.
// ----------------------------------------------------------------------------
module ncl_hist #(
  parameter int unsigned LEVELS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ncl_pkg::hist_ctl_t        ctl_i,
  input  logic [$clog2(LEVELS)-1:0] rd_addr_i,
  input  logic [$clog2(LEVELS)-1:0] wr_addr_i,
  input  logic [7:0]                wr_data_i,
  output logic [7:0]                rd_data_o
);
  import ncl_pkg::*;

  logic [7:0]        mem [LEVELS];
  logic [LEVELS-1:0] valid_q;
  logic [7:0]        rdata_q;
  logic              rvalid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        valid_q <= '0;
      end else if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // An entry never written since the last clear reads as zero.
  assign rd_data_o = rvalid_q ? rdata_q : 8'd0;

endmodule

/* hdl/node_command_level_controller.sv */
// ----------------------------------------------------------------------------
// node_command_level_controller: command decoder and level estimator
// Decodes command messages, keeps a sliding-window mode estimate of the hop
// count and runs the wave, blink, discover and delayed-request timers.
// ----------------------------------------------------------------------------
// A tick beat passes through StTick; a message beat passes through StIncRd,
// StIncWr, StScan, StClr, StDecRd and StDecWr, then StMul1 and StMul2 when it
// starts a wave, and StDone, as the histogram scan reads one entry per cycle.
// The next beat is taken only once the block is back in StIdle.
// A result stalled downstream holds only the final step. Reset is asynchronous,
// active low, and clears the histogram at once through its per-entry valid bits.
module node_command_level_controller #(
  parameter int unsigned LEVELS = ncl_pkg::LevelsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] hop_count_i,
  input  logic [2:0] command_i,
  input  logic [4:0] window_size_i,
  input  logic [3:0] led_delay_i,
  input  logic [3:0] led_duration_i,
  input  logic       direction_bit_i,
  input  logic [6:0] level_field_i,
  input  logic [7:0] radio_power_i,
  input  logic [7:0] mac_delay_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       red_on_o,
  output logic       yellow_on_o,
  output logic       power_write_o,
  output logic [7:0] power_value_o,
  output logic       proximity_start_o,
  output logic       proximity_mode_out_o,
  output logic       shutdown_start_o,
  output logic [7:0] mac_delay_high_o,
  output logic [6:0] node_level_o
);
  import ncl_pkg::*;

  localparam int unsigned LvlW = $clog2(LEVELS);
  localparam int unsigned CntW = LvlW + 1;
  localparam int unsigned CmpW = (LvlW > 7) ? LvlW : 7;

  typedef enum logic [3:0] {
    StIdle, StTick, StIncRd, StIncWr, StScan, StClr,
    StDecRd, StDecWr, StMul1, StMul2, StDone
  } state_e;

  state_e state_q;

  // Latched message fields.
  logic [2:0]      cmd_q;
  logic [4:0]      wsize_q;
  logic [3:0]      ldelay_q, ldur_q;
  logic            dir_q;
  logic [6:0]      lfield_q;
  logic [7:0]      power_in_q, mac_in_q;
  logic [LvlW-1:0] lvl_q;

  // Block state.
  logic [LvlW-1:0] ring_q [RingDepth];
  logic [4:0]      ring_pos_q, hist_len_q;
  logic [7:0]      power_q, mac_q, act_cnt_q, adt_q;
  logic [6:0]      tphs_q, my_level_q, max_depth_q, wave_on_q;
  logic            wave_run_q, blink_q, act_shut_q, act_mode_q, red_q, yel_q;
  logic [15:0]     wave_delay_q;
  logic [2:0]      blink_ph_q;
  logic [1:0]      disc_ph_q;

  // Sequencer working registers.
  logic [CntW-1:0] scan_cnt_q;
  logic [7:0]      top_q;
  logic [LvlW-1:0] best_q, old_q;
  logic            pw_q;
  logic [10:0]     prod1_q;

  // Result register.
  logic       out_valid_q, o_red_q, o_yel_q, o_pw_q, o_prox_q, o_mode_q, o_shut_q;
  logic [7:0] o_power_q, o_mac_q;
  logic [6:0] o_level_q;

  hist_ctl_t       hctl;
  logic [LvlW-1:0] h_rd_addr, h_wr_addr;
  logic [7:0]      h_wr_data, h_rd_data;

  ncl_hist #(.LEVELS(LEVELS)) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (hctl),
    .rd_addr_i (h_rd_addr),
    .wr_addr_i (h_wr_addr),
    .wr_data_i (h_wr_data),
    .rd_data_o (h_rd_data)
  );

  logic in_acc, out_free, res_load;
  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  // The result register takes a new beat when the last step of an item finds it free.
  assign res_load   = ((state_q == StTick) || (state_q == StDone)) && out_free;

  // Hop count clipped to the top level.
  logic [LvlW-1:0] lvl_in;
  always_comb begin
    if ({1'b0, hop_count_i} > 9'(LEVELS - 1)) begin
      lvl_in = LvlW'(LEVELS - 1);
    end else begin
      lvl_in = LvlW'(hop_count_i);
    end
  end

  // Scan bookkeeping: the entry being compared is the one read on the previous scan step.
  logic [LvlW-1:0] scan_idx, cmp_idx, old_rd;
  assign scan_idx = scan_cnt_q[LvlW-1:0];
  assign cmp_idx  = LvlW'(scan_cnt_q - CntW'(1));
  assign old_rd   = ring_q[ring_pos_q];

  logic clear_need;
  logic [4:0] ring_pos_nx;
  assign clear_need = (hist_len_q != wsize_q) || (cmd_q == CmdClear);
  always_comb begin
    if (hist_len_q != 5'd0 && ({1'b0, ring_pos_q} + 6'd1) < {1'b0, hist_len_q}) begin
      ring_pos_nx = ring_pos_q + 5'd1;
    end else begin
      ring_pos_nx = 5'd0;
    end
  end

  always_comb begin
    hctl      = '0;
    h_rd_addr = lvl_q;
    h_wr_addr = lvl_q;
    h_wr_data = (h_rd_data == 8'hff) ? h_rd_data : h_rd_data + 8'd1;
    unique case (state_q)
      StIncRd: hctl.rd_en = 1'b1;
      StIncWr: hctl.wr_en = 1'b1;
      StScan: begin
        hctl.rd_en = (scan_cnt_q < CntW'(LEVELS));
        h_rd_addr  = scan_idx;
      end
      StClr:   hctl.clr = clear_need;
      StDecRd: begin
        hctl.rd_en = 1'b1;
        h_rd_addr  = old_rd;
      end
      StDecWr: begin
        hctl.wr_en = (h_rd_data != 8'd0);
        h_wr_addr  = old_q;
        h_wr_data  = h_rd_data - 8'd1;
      end
      default: ;
    endcase
  end

  // Tick update, worked out from the present state in one step.
  logic        t_red, t_yel, t_run, t_prox, t_mode, t_shut;
  logic [15:0] t_delay;
  logic [6:0]  t_on;
  logic [2:0]  t_bph;
  logic [1:0]  t_dph;
  logic [7:0]  t_act;
  always_comb begin
    t_red = red_q; t_yel = yel_q; t_run = wave_run_q;
    t_delay = wave_delay_q; t_on = wave_on_q;
    t_bph = blink_ph_q; t_dph = disc_ph_q; t_act = act_cnt_q;
    t_prox = 1'b0; t_mode = 1'b0; t_shut = 1'b0;
    if (wave_run_q) begin
      if (wave_delay_q != 16'd0) begin
        t_delay = wave_delay_q - 16'd1;
        if (wave_delay_q == 16'd1) begin
          t_red = 1'b1; t_yel = 1'b0;
        end
      end else if (wave_on_q != 7'd0) begin
        t_on = wave_on_q - 7'd1;
        if (wave_on_q == 7'd1) begin
          t_red = 1'b0; t_yel = 1'b0; t_run = 1'b0;
        end
      end
    end
    if (blink_q) begin
      if (blink_ph_q < BlinkOnTicks) begin
        t_red = 1'b1; t_bph = blink_ph_q + 3'd1;
      end else begin
        t_red = 1'b0; t_bph = 3'd0;
      end
    end
    if (disc_ph_q != 2'd0) begin
      t_yel = 1'b1; t_red = 1'b0;
      if (disc_ph_q >= DiscoverLast) begin
        t_yel = 1'b0; t_dph = 2'd0;
      end else begin
        t_dph = disc_ph_q + 2'd1;
      end
    end
    if (act_cnt_q != 8'd0) begin
      if (act_cnt_q >= adt_q) begin
        t_shut = act_shut_q;
        t_prox = !act_shut_q;
        t_mode = !act_shut_q && act_mode_q;
        t_act  = 8'd0;
      end else begin
        t_act = act_cnt_q + 8'd1;
      end
    end
  end

  // Message update of the LED, blink, request and level state.
  logic            m_red, m_yel, m_blink, m_act_set;
  logic [6:0]      m_maxd;
  logic [CmpW-1:0] m_clip;
  always_comb begin
    m_red = red_q; m_yel = yel_q; m_blink = blink_q; m_act_set = 1'b0;
    unique case (cmd_q)
      CmdLedOn: begin
        m_red = 1'b0; m_yel = 1'b1;
      end
      CmdLedOff: begin
        m_red = 1'b0; m_yel = 1'b0;
      end
      CmdProximity, CmdShutdown: m_act_set = (act_cnt_q == 8'd0);
      CmdBlinkLevel: begin
        if (lfield_q == my_level_q) begin
          m_blink = 1'b1; m_yel = 1'b0;
        end else begin
          m_blink = 1'b0; m_red = 1'b0; m_yel = 1'b0;
        end
      end
      default: ;
    endcase
    if (blink_q && cmd_q != CmdBlinkLevel) begin
      m_blink = 1'b0; m_red = 1'b0;
    end
    m_maxd = (cmd_q != CmdBlinkLevel) ? lfield_q : max_depth_q;
    m_clip = (CmpW'(best_q) > CmpW'(m_maxd)) ? CmpW'(m_maxd) : CmpW'(best_q);
  end

  // Wave timing products, worked out over StMul1 and StMul2.
  logic [6:0]  span;
  logic [10:0] dur;
  logic [17:0] prod;
  always_comb begin
    if (dir_q) begin
      span = (max_depth_q > my_level_q) ? max_depth_q - my_level_q : 7'd0;
    end else begin
      span = my_level_q;
    end
    dur  = 11'(ldur_q) * 11'(tphs_q);
    prod = 18'(prod1_q) * 18'(tphs_q);
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q      <= command_i;
      wsize_q    <= window_size_i;
      ldelay_q   <= led_delay_i;
      ldur_q     <= led_duration_i;
      dir_q      <= direction_bit_i;
      lfield_q   <= level_field_i;
      power_in_q <= radio_power_i;
      mac_in_q   <= mac_delay_byte_i;
      lvl_q      <= lvl_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      ring_q       <= '{default: '0};
      ring_pos_q   <= 5'd0;
      hist_len_q   <= HistLenReset;
      power_q      <= PowerReset;
      mac_q        <= 8'd0;
      act_cnt_q    <= 8'd0;
      adt_q        <= ActionDelayReset;
      tphs_q       <= TphsReset;
      my_level_q   <= 7'd0;
      max_depth_q  <= 7'd0;
      wave_on_q    <= 7'd0;
      wave_run_q   <= 1'b0;
      wave_delay_q <= 16'd0;
      blink_q      <= 1'b0;
      blink_ph_q   <= 3'd0;
      disc_ph_q    <= 2'd0;
      act_shut_q   <= 1'b0;
      act_mode_q   <= 1'b0;
      red_q        <= 1'b1;
      yel_q        <= 1'b0;
      scan_cnt_q   <= '0;
      top_q        <= 8'd0;
      best_q       <= '0;
      old_q        <= '0;
      pw_q         <= 1'b0;
      prod1_q      <= 11'd0;
      out_valid_q  <= 1'b0;
      o_red_q      <= 1'b0;
      o_yel_q      <= 1'b0;
      o_pw_q       <= 1'b0;
      o_prox_q     <= 1'b0;
      o_mode_q     <= 1'b0;
      o_shut_q     <= 1'b0;
      o_power_q    <= 8'd0;
      o_mac_q      <= 8'd0;
      o_level_q    <= 7'd0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegActionDelay) begin
          adt_q <= cfg_data_i;
        end else begin
          tphs_q <= cfg_data_i[6:0];
        end
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            state_q <= kind_i ? StTick : StIncRd;
          end
        end
        StTick: begin
          if (out_free) begin
            red_q        <= t_red;
            yel_q        <= t_yel;
            wave_run_q   <= t_run;
            wave_delay_q <= t_delay;
            wave_on_q    <= t_on;
            blink_ph_q   <= t_bph;
            disc_ph_q    <= t_dph;
            act_cnt_q    <= t_act;
            o_red_q      <= t_red;
            o_yel_q      <= t_yel;
            o_pw_q       <= 1'b0;
            o_prox_q     <= t_prox;
            o_mode_q     <= t_mode;
            o_shut_q     <= t_shut;
            o_power_q    <= power_q;
            o_mac_q      <= mac_q;
            o_level_q    <= my_level_q;
            state_q      <= StIdle;
          end
        end
        StIncRd: begin
          ring_q[ring_pos_q] <= lvl_q;
          state_q            <= StIncWr;
        end
        StIncWr: begin
          scan_cnt_q <= '0;
          top_q      <= 8'd0;
          best_q     <= lvl_q;
          state_q    <= StScan;
        end
        StScan: begin
          // Strictly greater keeps the lowest level among equal counts.
          if (scan_cnt_q != '0 && h_rd_data > top_q) begin
            top_q  <= h_rd_data;
            best_q <= cmp_idx;
          end
          if (scan_cnt_q == CntW'(LEVELS)) begin
            state_q <= StClr;
          end else begin
            scan_cnt_q <= scan_cnt_q + CntW'(1);
          end
        end
        StClr: begin
          if (clear_need) begin
            ring_q <= '{default: '0};
          end
          ring_pos_q <= ring_pos_nx;
          hist_len_q <= wsize_q;
          state_q    <= StDecRd;
        end
        StDecRd: begin
          old_q   <= old_rd;
          state_q <= StDecWr;
        end
        StDecWr: begin
          red_q   <= m_red;
          yel_q   <= m_yel;
          blink_q <= m_blink;
          if (m_act_set) begin
            act_cnt_q  <= 8'd1;
            act_shut_q <= (cmd_q == CmdShutdown);
            act_mode_q <= dir_q;
          end
          pw_q        <= (power_in_q != power_q);
          power_q     <= power_in_q;
          mac_q       <= mac_q | mac_in_q;
          max_depth_q <= m_maxd;
          if (cmd_q == CmdDiscover) begin
            my_level_q <= m_clip[6:0];
            disc_ph_q  <= 2'd1;
          end
          state_q   <= ((cmd_q == CmdWave) && !wave_run_q) ? StMul1 : StDone;
        end
        StMul1: begin
          prod1_q    <= 11'(ldelay_q) * 11'(span);
          wave_on_q  <= (dur > 11'd127) ? 7'd127 : dur[6:0];
          wave_run_q <= 1'b1;
          state_q    <= StMul2;
        end
        StMul2: begin
          if (prod > 18'hffff) begin
            wave_delay_q <= 16'hffff;
          end else if (dir_q && prod == 18'd0) begin
            wave_delay_q <= 16'd1;
          end else begin
            wave_delay_q <= prod[15:0];
          end
          state_q <= StDone;
        end
        StDone: begin
          if (out_free) begin
            o_red_q     <= red_q;
            o_yel_q     <= yel_q;
            o_pw_q      <= pw_q;
            o_prox_q    <= 1'b0;
            o_mode_q    <= 1'b0;
            o_shut_q    <= 1'b0;
            o_power_q   <= power_q;
            o_mac_q     <= mac_q;
            o_level_q   <= my_level_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o          = out_valid_q;
  assign red_on_o             = o_red_q;
  assign yellow_on_o          = o_yel_q;
  assign power_write_o        = o_pw_q;
  assign power_value_o        = o_power_q;
  assign proximity_start_o    = o_prox_q;
  assign proximity_mode_out_o = o_mode_q;
  assign shutdown_start_o     = o_shut_q;
  assign mac_delay_high_o     = o_mac_q;
  assign node_level_o         = o_level_q;

endmodule

/* hdl/ncl_checker.sv */
// ----------------------------------------------------------------------------
// ncl_checker: port-level checks
// Watches the top level's ports and reports rule breaches.
// ----------------------------------------------------------------------------
module ncl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic proximity_start_o,
  input logic proximity_mode_out_o,
  input logic shutdown_start_o
);

  // A result beat waiting on the far side stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // The block works on one beat at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("beat accepted while the previous one is in work");

  // A request is either proximity or shutdown, never both.
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(proximity_start_o && shutdown_start_o))
    else $error("proximity and shutdown requested together");

  // The mode bit only travels with a proximity request.
  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !proximity_start_o |-> !proximity_mode_out_o)
    else $error("proximity mode set without a request");

endmodule

bind node_command_level_controller ncl_checker u_ncl_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_stall_o           (in_stall_o),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .proximity_start_o    (proximity_start_o),
  .proximity_mode_out_o (proximity_mode_out_o),
  .shutdown_start_o     (shutdown_start_o)
);

/* sim/node_command_level_controller_tb.sv */
// ----------------------------------------------------------------------------
// node_command_level_controller_tb: self-checking testbench
// Drives message and tick beats through the controller under random idling on
// both channels. A behavioural predictor computes the expected result of each
// accepted beat, and every result beat is checked field by field in order.
// ----------------------------------------------------------------------------
module node_command_level_controller_tb;
  import ncl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumLevels  = 64;

  // One input beat, one field per port.
  typedef struct {
    logic       kind;
    logic [7:0] hop;
    logic [2:0] cmd;
    logic [4:0] wsize;
    logic [3:0] ldelay;
    logic [3:0] ldur;
    logic       dir;
    logic [6:0] lfield;
    logic [7:0] power;
    logic [7:0] macb;
  } beat_t;

  // One result beat.
  typedef struct {
    logic       red;
    logic       yellow;
    logic       pwr_wr;
    logic [7:0] pwr_val;
    logic       prox;
    logic       req_mode;
    logic       shut;
    logic [7:0] mac_high;
    logic [6:0] level;
  } status_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       kind_i = 1'b0;
  logic [7:0] hop_count_i = '0;
  logic [2:0] command_i = '0;
  logic [4:0] window_size_i = '0;
  logic [3:0] led_delay_i = '0;
  logic [3:0] led_duration_i = '0;
  logic       direction_bit_i = 1'b0;
  logic [6:0] level_field_i = '0;
  logic [7:0] radio_power_i = '0;
  logic [7:0] mac_delay_byte_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       red_on_o, yellow_on_o, power_write_o;
  logic [7:0] power_value_o;
  logic       proximity_start_o, proximity_mode_out_o, shutdown_start_o;
  logic [7:0] mac_delay_high_o;
  logic [6:0] node_level_o;

  node_command_level_controller dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: a copy of the controller's registers and its histogram.
  logic [7:0] act_delay_cfg;
  logic [6:0] tphs_cfg;
  logic [7:0] hist_counts [NumLevels];
  logic [5:0] sample_ring [32];
  logic [4:0] ring_pos, hist_len;
  logic [7:0] power_reg, mac_reg;
  logic       wave_running;
  logic [15:0] wave_delay;
  logic [6:0] wave_on, my_level, max_depth;
  logic       blinking;
  logic [2:0] blink_phase;
  logic [1:0] disc_phase;
  logic [7:0] act_count;
  logic       act_shut, act_mode;
  logic       red_reg, yellow_reg;

  status_t    status_q [$];
  bit         failed = 1'b0;
  bit         steady = 1'b0;  // when set, neither side idles
  int unsigned cycles = 0;
  logic [4:0] cur_wsize = 5'd15;

  task automatic model_reset();
    act_delay_cfg = ActionDelayReset;
    tphs_cfg      = TphsReset;
    foreach (hist_counts[i]) hist_counts[i] = '0;
    foreach (sample_ring[i]) sample_ring[i] = '0;
    ring_pos = '0; hist_len = HistLenReset; power_reg = PowerReset;
    wave_running = 1'b0; wave_delay = '0; wave_on = '0;
    my_level = '0; max_depth = '0; blinking = 1'b0; blink_phase = '0;
    disc_phase = '0; act_count = '0; act_shut = 1'b0; act_mode = 1'b0;
    red_reg = 1'b1; yellow_reg = 1'b0; mac_reg = '0;
  endtask

  // Sliding-window mode: store and count the sample, scan for the lowest
  // index holding the top count, then clear and advance the window.
  function automatic int unsigned hist_mode(int unsigned hop, logic [2:0] cmd,
                                            logic [4:0] wsize);
    int unsigned lvl, best, top;
    logic [5:0] old;
    lvl  = (hop > NumLevels - 1) ? NumLevels - 1 : hop;
    best = lvl;
    top  = 0;
    sample_ring[ring_pos] = lvl[5:0];
    if (hist_counts[lvl] < 8'd255) hist_counts[lvl]++;
    for (int i = 0; i < NumLevels; i++) begin
      if (hist_counts[i] > top) begin
        top  = hist_counts[i];
        best = i;
      end
    end
    if (hist_len != wsize || cmd == CmdClear) begin
      foreach (hist_counts[i]) hist_counts[i] = '0;
      foreach (sample_ring[i]) sample_ring[i] = '0;
    end
    if (hist_len != 0 && int'(ring_pos) + 1 < int'(hist_len)) ring_pos++;
    else ring_pos = '0;
    old = sample_ring[ring_pos];
    if (hist_counts[old] > 0) hist_counts[old]--;
    hist_len = wsize;
    return best;
  endfunction

  function automatic status_t next_status(beat_t b);
    status_t s;
    bit wave_go;
    int unsigned lvl, span, prod, dur;
    s = '{default: '0};
    wave_go = 1'b0;
    if (!b.kind) begin
      case (b.cmd)
        CmdLedOn: begin red_reg = 1'b0; yellow_reg = 1'b1; end
        CmdLedOff: begin red_reg = 1'b0; yellow_reg = 1'b0; end
        CmdWave: wave_go = !wave_running;
        CmdProximity, CmdShutdown: begin
          if (act_count == 0) begin
            act_count = 8'd1;
            act_shut  = (b.cmd == CmdShutdown);
            act_mode  = b.dir;
          end
        end
        CmdBlinkLevel: begin
          if (b.lfield == my_level) begin
            blinking = 1'b1; yellow_reg = 1'b0;
          end else begin
            blinking = 1'b0; red_reg = 1'b0; yellow_reg = 1'b0;
          end
        end
        default: ;
      endcase
      // Any other command cancels a level blink.
      if (blinking && b.cmd != CmdBlinkLevel) begin
        blinking = 1'b0;
        red_reg  = 1'b0;
      end
      if (b.power != power_reg) begin
        power_reg = b.power;
        s.pwr_wr  = 1'b1;
      end
      mac_reg = mac_reg | b.macb;
      lvl = hist_mode(b.hop, b.cmd, b.wsize);
      if (b.cmd != CmdBlinkLevel) max_depth = b.lfield;
      if (lvl > max_depth) lvl = max_depth;
      if (b.cmd == CmdDiscover) begin
        my_level   = lvl[6:0];
        disc_phase = 2'd1;
      end
      if (wave_go) begin
        wave_running = 1'b1;
        if (!b.dir) span = my_level;
        else span = (max_depth > my_level) ? max_depth - my_level : 0;
        prod = b.ldelay * span * tphs_cfg;
        if (prod > 16'hffff) prod = 16'hffff;
        if (b.dir && prod == 0) prod = 1;
        wave_delay = prod[15:0];
        dur = b.ldur * tphs_cfg;
        wave_on = (dur > 127) ? 7'd127 : dur[6:0];
      end
    end else begin
      if (wave_running) begin
        if (wave_delay != 0) begin
          wave_delay--;
          if (wave_delay == 0) begin red_reg = 1'b1; yellow_reg = 1'b0; end
        end else if (wave_on != 0) begin
          wave_on--;
          if (wave_on == 0) begin
            red_reg = 1'b0; yellow_reg = 1'b0; wave_running = 1'b0;
          end
        end
      end
      if (blinking) begin
        if (blink_phase < BlinkOnTicks) begin
          red_reg = 1'b1; blink_phase++;
        end else begin
          red_reg = 1'b0; blink_phase = '0;
        end
      end
      if (disc_phase != 0) begin
        yellow_reg = 1'b1; red_reg = 1'b0;
        disc_phase++;
        if (disc_phase > DiscoverLast) begin
          yellow_reg = 1'b0; red_reg = 1'b0; disc_phase = '0;
        end
      end
      if (act_count != 0) begin
        if (act_count >= act_delay_cfg) begin
          if (act_shut) s.shut = 1'b1;
          else begin s.prox = 1'b1; s.req_mode = act_mode; end
          act_count = '0;
        end else begin
          act_count++;
        end
      end
    end
    s.red = red_reg; s.yellow = yellow_reg; s.pwr_val = power_reg;
    s.mac_high = mac_reg; s.level = my_level;
    return s;
  endfunction

  // Send one beat. Called just after a rising edge; returns just after the
  // edge at which the beat was accepted, with valid still high.
  task automatic send_beat(beat_t b);
    bit taken;
    if (!steady && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= b.kind; hop_count_i <= b.hop; command_i <= b.cmd;
    window_size_i <= b.wsize; led_delay_i <= b.ldelay; led_duration_i <= b.ldur;
    direction_bit_i <= b.dir; level_field_i <= b.lfield;
    radio_power_i <= b.power; mac_delay_byte_i <= b.macb;
    // Stall only moves at a rising edge, so its value at the falling edge
    // is the one the next rising edge will see.
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    status_q.push_back(next_status(b));
  endtask

  task automatic send_msg(logic [2:0] cmd, logic [7:0] hop, logic [6:0] lfield,
                          logic [3:0] ldelay = 4'd1, logic [3:0] ldur = 4'd1,
                          logic dir = 1'b0, logic [7:0] power = 8'd70,
                          logic [7:0] macb = 8'd0);
    beat_t b;
    b = '{kind: 1'b0, hop: hop, cmd: cmd, wsize: cur_wsize, ldelay: ldelay,
          ldur: ldur, dir: dir, lfield: lfield, power: power, macb: macb};
    send_beat(b);
  endtask

  task automatic send_ticks(int unsigned n);
    beat_t b;
    b = '{default: '0};
    b.kind = 1'b1;
    repeat (n) begin
      // Message fields are ignored on a tick, so they carry noise.
      b.hop = 8'($urandom); b.cmd = 3'($urandom); b.lfield = 7'($urandom);
      send_beat(b);
    end
  endtask

  // Wait until the block has drained, then write one register.
  task automatic write_reg(logic idx, logic [7:0] value);
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegActionDelay) act_delay_cfg = value;
    else tphs_cfg = value[6:0];
  endtask

  task automatic test_reset_and_extremes();
    send_ticks(1);
    send_msg(CmdClear, 8'd0, 7'd0, 4'd0, 4'd0, 1'b0, 8'd0, 8'd0);
    send_msg(CmdLedOn, 8'd255, 7'd127, 4'd15, 4'd15, 1'b1, 8'd255, 8'h0f);
    send_msg(CmdLedOff, 8'd63, 7'd64, 4'd0, 4'd0, 1'b0, 8'd255, 8'hf0);
    cur_wsize = 5'd31;
    send_msg(CmdClear, 8'd64, 7'd10);
    cur_wsize = 5'd0;
    send_msg(CmdLedOff, 8'd5, 7'd10);
    send_msg(CmdLedOff, 8'd5, 7'd10);
    cur_wsize = 5'd15;
  endtask

  task automatic test_discover();
    send_msg(CmdLedOn, 8'd3, 7'd20);
    send_msg(CmdLedOn, 8'd3, 7'd20);
    send_msg(CmdLedOn, 8'd7, 7'd20);
    send_msg(CmdDiscover, 8'd7, 7'd20);
    send_ticks(3);
    // Mode above the network depth is clipped to it.
    send_msg(CmdDiscover, 8'd200, 7'd2);
    send_ticks(3);
  endtask

  task automatic test_wave();
    write_reg(RegTicksPerHalf, 8'd1);
    send_msg(CmdDiscover, 8'd3, 7'd10);
    send_msg(CmdWave, 8'd3, 7'd10, 4'd2, 4'd3, 1'b0);
    send_msg(CmdWave, 8'd3, 7'd10, 4'd9, 4'd9, 1'b1);
    send_ticks(14);
    send_msg(CmdWave, 8'd3, 7'd10, 4'd1, 4'd2, 1'b1);
    send_ticks(14);
    // Reverse wave with no span is forced to a one-tick delay.
    send_msg(CmdWave, 8'd3, 7'd0, 4'd3, 4'd1, 1'b1);
    send_ticks(4);
    write_reg(RegTicksPerHalf, 8'd64);
    send_msg(CmdWave, 8'd3, 7'd0, 4'd0, 4'd15, 1'b0);
    send_ticks(10);
    write_reg(RegTicksPerHalf, 8'd127);
    send_msg(CmdWave, 8'd3, 7'd127, 4'd15, 4'd1, 1'b1);
    send_msg(CmdClear, 8'd3, 7'd0);
    send_ticks(3);
  endtask

  task automatic test_blink();
    send_msg(CmdBlinkLevel, 8'd1, my_level);
    send_ticks(12);
    send_msg(CmdLedOn, 8'd1, 7'd10);
    send_msg(CmdBlinkLevel, 8'd1, my_level + 7'd1);
    send_ticks(2);
  endtask

  task automatic test_requests();
    write_reg(RegActionDelay, 8'd1);
    send_msg(CmdProximity, 8'd1, 7'd5, 4'd0, 4'd1, 1'b1);
    send_ticks(2);
    send_msg(CmdShutdown, 8'd1, 7'd5);
    send_ticks(1);
    write_reg(RegActionDelay, 8'd0);
    send_msg(CmdProximity, 8'd1, 7'd5, 4'd0, 4'd1, 1'b0);
    send_ticks(1);
    write_reg(RegActionDelay, 8'd40);
    send_msg(CmdShutdown, 8'd1, 7'd5);
    send_msg(CmdProximity, 8'd1, 7'd5, 4'd0, 4'd1, 1'b1);  // still pending
    send_ticks(41);
  endtask

  // Mostly runs of messages with a steady window so the histogram fills,
  // mixed with bursts of ticks to carry waves, blinks and requests through.
  task automatic test_random(int unsigned n);
    beat_t b;
    write_reg(RegActionDelay, 8'($urandom_range(1, 20)));
    write_reg(RegTicksPerHalf, 8'($urandom_range(1, 3)));
    for (int unsigned k = 0; k < n; k++) begin
      steady = (k >= n / 3 && k < n / 2);
      if ($urandom_range(0, 99) < 8) begin
        send_ticks($urandom_range(5, 30));
      end else if ($urandom_range(0, 99) < 45) begin
        send_ticks(1);
      end else begin
        if ($urandom_range(0, 99) < 4) cur_wsize = 5'($urandom);
        else if ($urandom_range(0, 99) < 4) cur_wsize = 5'd15;
        b.kind   = 1'b0;
        b.hop    = 8'(($urandom_range(0, 99) < 75) ? $urandom_range(0, 12) : $urandom);
        b.cmd    = 3'($urandom);
        b.wsize  = cur_wsize;
        b.ldelay = 4'($urandom);
        b.ldur   = 4'($urandom_range(1, 15));
        b.dir    = 1'($urandom);
        b.lfield = 7'(($urandom_range(0, 99) < 75) ? $urandom_range(0, 20) : $urandom);
        if (b.cmd == CmdBlinkLevel && $urandom_range(0, 1)) b.lfield = my_level;
        b.power  = ($urandom_range(0, 99) < 80) ? power_reg : 8'($urandom);
        b.macb   = ($urandom_range(0, 99) < 10) ? 8'($urandom) : 8'd0;
        send_beat(b);
      end
    end
    steady = 1'b0;
  endtask

  // A wave with no on-time never finishes; further waves are then ignored.
  task automatic test_endless_wave();
    write_reg(RegTicksPerHalf, 8'd2);
    send_ticks(20);
    send_msg(CmdClear, 8'd0, 7'd0);
    send_ticks(20);
    send_msg(CmdWave, 8'd0, 7'd4, 4'd1, 4'd0, 1'b1);
    send_ticks(20);
    send_msg(CmdWave, 8'd0, 7'd4, 4'd1, 4'd5, 1'b0);
    send_ticks(20);
  endtask

  // Receiving side: random stall, with a quiet stretch while steady is set.
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < 12);
  end

  function automatic void compare(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Every result beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    status_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_q.size() == 0) begin
        $error("result beat with no prediction waiting");
        failed = 1'b1;
      end else begin
        e = status_q.pop_front();
        compare("red_on", e.red, red_on_o);
        compare("yellow_on", e.yellow, yellow_on_o);
        compare("power_write", e.pwr_wr, power_write_o);
        compare("power_value", e.pwr_val, power_value_o);
        compare("proximity_start", e.prox, proximity_start_o);
        compare("proximity_mode_out", e.req_mode, proximity_mode_out_o);
        compare("shutdown_start", e.shut, shutdown_start_o);
        compare("mac_delay_high", e.mac_high, mac_delay_high_o);
        compare("node_level", e.level, node_level_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("node_command_level_controller verification failed");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_and_extremes();
    test_discover();
    test_wave();
    test_blink();
    test_requests();
    test_random(120);
    test_endless_wave();
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (!failed && status_q.size() == 0) begin
      $display("node_command_level_controller verification clean");
    end else begin
      $display("node_command_level_controller verification failed");
    end
    $finish;
  end

endmodule
